// ----- sv/utcep_pkg.sv -----
`timescale 1ns / 1ps

package utcep_pkg;

    typedef struct packed {
        logic               cmd;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [26:0]        date_packed;
        logic signed [19:0] time_packed;
        logic [31:0]        nanoseconds_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] epoch_seconds;
        logic [29:0]        nanoseconds_out;
    } result_t;

    // Three decimal digit groups of a word: value / 10000, (value % 10000) / 100, value % 100.
    typedef struct packed {
        logic [13:0] hi;
        logic [6:0]  mid;
        logic [6:0]  lo;
    } split_t;

    // Exact reciprocals: floor(v * MUL / 2**SHIFT) equals the quotient over the whole input range.
    localparam logic [27:0] DIV10K_MUL   = 28'd219902326;
    localparam int          DIV10K_SHIFT = 41;
    localparam logic [14:0] DIV100_MUL   = 15'd20972;
    localparam int          DIV100_SHIFT = 21;
    localparam logic [12:0] DIV25_MUL    = 13'd5243;
    localparam int          DIV25_SHIFT  = 17;

    localparam int unsigned TEN_THOUSAND = 10000;
    localparam int unsigned HUNDRED      = 100;
    localparam int unsigned CENTURY_25   = 25;

    localparam int unsigned NS_PER_SEC   = 1000000000;
    localparam int          DAY_WORD     = 240000;
    localparam int          SEC_PER_DAY  = 86400;
    localparam int          SEC_PER_YEAR = 31536000;
    localparam int          SEC_PER_HOUR = 3600;
    localparam int          SEC_PER_MIN  = 60;

    localparam int unsigned YY_2000_MAX  = 37;
    localparam int unsigned YY_1900_MIN  = 70;
    localparam int unsigned YY_1900_MAX  = 137;
    localparam int unsigned CIVIL_BASE   = 1900;
    localparam int unsigned CENTURY      = 100;
    localparam int unsigned LEAP_BASE    = 69;
    localparam int unsigned EPOCH_YEAR   = 70;

    localparam int unsigned MONTH_FEB    = 2;
    localparam int unsigned MONTH_MAR    = 3;

    // Days of the year before the first of the given month. Month zero counts nothing and
    // months above December count the whole year.
    function automatic logic [8:0] days_before_month(input logic [6:0] mon, input logic leap);
        logic [8:0] base;
        begin
            unique case (mon)
                7'd0, 7'd1: base = 9'd0;
                7'd2:       base = 9'd31;
                7'd3:       base = 9'd59;
                7'd4:       base = 9'd90;
                7'd5:       base = 9'd120;
                7'd6:       base = 9'd151;
                7'd7:       base = 9'd181;
                7'd8:       base = 9'd212;
                7'd9:       base = 9'd243;
                7'd10:      base = 9'd273;
                7'd11:      base = 9'd304;
                7'd12:      base = 9'd334;
                default:    base = 9'd365;
            endcase
            if (leap && (mon >= 7'(MONTH_MAR)))
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

// ----- sv/utcep_dec_split.sv -----
`timescale 1ns / 1ps

module utcep_dec_split (
    input  logic              clk,
    input  logic [26:0]       value,
    output utcep_pkg::split_t digits
);

    logic [54:0] q_prod;
    logic [28:0] m_prod;

    logic [13:0] q1_reg, q1_next;
    logic [26:0] v1_reg, v1_next;
    logic [13:0] q2_reg, q2_next;
    logic [13:0] r2_reg, r2_next;
    logic [13:0] q3_reg, q3_next;
    logic [13:0] r3_reg, r3_next;
    logic [6:0]  m3_reg, m3_next;

    always_comb
    begin
        q_prod  = 55'(value) * 55'(utcep_pkg::DIV10K_MUL);
        q1_next = 14'(q_prod >> utcep_pkg::DIV10K_SHIFT);
        v1_next = value;

        q2_next = q1_reg;
        r2_next = 14'(v1_reg - 27'(q1_reg) * 27'(utcep_pkg::TEN_THOUSAND));

        m_prod  = 29'(r2_reg) * 29'(utcep_pkg::DIV100_MUL);
        q3_next = q2_reg;
        r3_next = r2_reg;
        m3_next = 7'(m_prod >> utcep_pkg::DIV100_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        q1_reg <= q1_next;
        v1_reg <= v1_next;
        q2_reg <= q2_next;
        r2_reg <= r2_next;
        q3_reg <= q3_next;
        r3_reg <= r3_next;
        m3_reg <= m3_next;
    end

    assign digits.hi  = q3_reg;
    assign digits.mid = m3_reg;
    assign digits.lo  = 7'(r3_reg - 14'(m3_reg) * 14'(utcep_pkg::HUNDRED));

endmodule

// ----- sv/utc_civil_to_epoch_seconds.sv -----
// UTC civil date and time to 32-bit seconds since 1970 with normalised nanoseconds.
//
// Input: an item is taken at a rising edge where start is high and busy is low. busy is
// high only during reset and in the first cycle after it, so an item may be presented on
// every cycle. cmd selects the component fields or the packed YYYYMMDD / HHMMSS words.
// Output: each item gives one result, shown on result for exactly one cycle with done
// high. An item passes through the registered stages A to I and the result register, and
// the throughput is one item per cycle. The depth of the pipeline is set by the
// chain of reciprocal multiplies that split the decimal words and test for leap years.
// The receiver cannot stall: every result is a transfer at the edge that ends its cycle.
// Configuration: the zone offset is written by a valid/ready transfer on cfg_valid and
// cfg_ready, and should only change while no item is in flight.
// Reset: rst_n clears the pipeline valid bits and sets the zone offset to zero; items in
// flight at reset are dropped without a result.
`timescale 1ns / 1ps

module utc_civil_to_epoch_seconds (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  utcep_pkg::item_t    item,
    output logic                done,
    output utcep_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic signed [17:0]  zone_offset_seconds
);

    typedef struct packed {
        logic               cmd;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic signed [2:0]  adj;
        logic [2:0]         carry;
        logic [29:0]        rem;
    } side_t;

    logic accept;

    // Control state
    logic               busy_reg, busy_next;
    logic signed [17:0] zone_reg, zone_next;
    logic [9:0]         vld_reg, vld_next;

    // Stage A: input register
    utcep_pkg::item_t   item_a_reg, item_a_next;

    // Stage B: wrapped time word and nanosecond carry
    side_t              side_b_reg, side_b_next;
    logic [26:0]        date_b_reg, date_b_next;
    logic [17:0]        time_b_reg, time_b_next;

    // Stages C to E run beside the decimal splitters
    side_t              side_c_reg, side_d_reg, side_e_reg;

    // Stage F: selected fields and mapped year
    logic [13:0]        ty_f_reg, ty_f_next;
    logic [13:0]        yfull_f_reg, yfull_f_next;
    logic [6:0]         mon_f_reg, mon_f_next;
    logic signed [7:0]  day_f_reg, day_f_next;
    logic [4:0]         hour_f_reg, hour_f_next;
    logic [6:0]         min_f_reg, min_f_next;
    logic [6:0]         sec_f_reg, sec_f_next;
    logic [2:0]         carry_f_reg;
    logic [29:0]        rem_f_reg;

    // Stage G: century quotient and leap-day term
    logic [13:0]        ty_g_reg;
    logic [13:0]        yfull_g_reg;
    logic [9:0]         q25_g_reg, q25_g_next;
    logic signed [12:0] leapq_g_reg, leapq_g_next;
    logic [6:0]         mon_g_reg;
    logic signed [7:0]  day_g_reg;
    logic [16:0]        hms_g_reg, hms_g_next;
    logic [2:0]         carry_g_reg;
    logic [29:0]        rem_g_reg;

    // Stage H: day count and year offset
    logic signed [13:0] days_h_reg, days_h_next;
    logic signed [14:0] tyoff_h_reg, tyoff_h_next;
    logic [16:0]        hms_h_reg;
    logic [2:0]         carry_h_reg;
    logic [29:0]        rem_h_reg;

    // Stage I: partial sums
    logic [31:0]        pyear_i_reg, pyear_i_next;
    logic [31:0]        prest_i_reg, prest_i_next;
    logic [29:0]        rem_i_reg;

    utcep_pkg::result_t result_reg, result_next;

    // Combinational helpers
    logic signed [20:0] t_s;
    logic signed [20:0] day_w1, day_w2, day_w3;
    logic [31:0]        ns;
    utcep_pkg::split_t  dsplit, tsplit;
    logic [13:0]        yr;
    logic signed [7:0]  dlo_s, adj_s;
    logic [13:0]        ldiff;
    logic [11:0]        lq_mag;
    logic               ty_below;
    logic               mult25, leap;
    logic [8:0]         cum;
    logic [31:0]        days_ext, zone_ext;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign done      = vld_reg[9];
    assign result    = result_reg;

    assign day_w1 = 21'(utcep_pkg::DAY_WORD);
    assign day_w2 = 21'(2 * utcep_pkg::DAY_WORD);
    assign day_w3 = 21'(3 * utcep_pkg::DAY_WORD);

    always_comb
    begin
        busy_next   = 1'b0;
        zone_next   = (cfg_valid && cfg_ready) ? zone_offset_seconds : zone_reg;
        vld_next    = {vld_reg[8:0], accept};
        item_a_next = accept ? item : item_a_reg;
    end

    // Stage A to B: wrap the time word by whole days and split off whole seconds.
    always_comb
    begin
        t_s = 21'(item_a_reg.time_packed);
        ns  = item_a_reg.nanoseconds_in;

        side_b_next.cmd    = item_a_reg.cmd;
        side_b_next.year   = item_a_reg.year;
        side_b_next.month  = item_a_reg.month;
        side_b_next.day    = item_a_reg.day;
        side_b_next.hour   = item_a_reg.hour;
        side_b_next.minute = item_a_reg.minute;
        side_b_next.second = item_a_reg.second;

        priority if (t_s < -day_w2)
        begin
            time_b_next     = 18'(t_s + day_w3);
            side_b_next.adj = -3'sd3;
        end
        else if (t_s < -day_w1)
        begin
            time_b_next     = 18'(t_s + day_w2);
            side_b_next.adj = -3'sd2;
        end
        else if (t_s < 21'sd0)
        begin
            time_b_next     = 18'(t_s + day_w1);
            side_b_next.adj = -3'sd1;
        end
        else if (t_s <= day_w1)
        begin
            // A word of exactly one day stays as hour 24.
            time_b_next     = 18'(t_s);
            side_b_next.adj = 3'sd0;
        end
        else if (t_s <= day_w2)
        begin
            time_b_next     = 18'(t_s - day_w1);
            side_b_next.adj = 3'sd1;
        end
        else
        begin
            time_b_next     = 18'(t_s - day_w2);
            side_b_next.adj = 3'sd2;
        end

        priority if (ns >= 32'(4 * utcep_pkg::NS_PER_SEC))
        begin
            side_b_next.carry = 3'd4;
        end
        else if (ns >= 32'(3 * utcep_pkg::NS_PER_SEC))
        begin
            side_b_next.carry = 3'd3;
        end
        else if (ns >= 32'(2 * utcep_pkg::NS_PER_SEC))
        begin
            side_b_next.carry = 3'd2;
        end
        else if (ns >= 32'(utcep_pkg::NS_PER_SEC))
        begin
            side_b_next.carry = 3'd1;
        end
        else
        begin
            side_b_next.carry = 3'd0;
        end
        side_b_next.rem = 30'(ns - 32'(side_b_next.carry) * 32'(utcep_pkg::NS_PER_SEC));

        date_b_next = item_a_reg.date_packed;
    end

    utcep_dec_split u_date_split (
        .clk    (clk),
        .value  (date_b_reg),
        .digits (dsplit)
    );

    utcep_dec_split u_time_split (
        .clk    (clk),
        .value  (27'(time_b_reg)),
        .digits (tsplit)
    );

    // Stage E to F: pick the fields for the command and map short years.
    always_comb
    begin
        dlo_s = signed'({1'b0, dsplit.lo});
        adj_s = 8'(side_e_reg.adj);

        if (side_e_reg.cmd)
        begin
            yr          = dsplit.hi;
            mon_f_next  = dsplit.mid;
            day_f_next  = dlo_s + adj_s;
            hour_f_next = 5'(tsplit.hi);
            min_f_next  = tsplit.mid;
            sec_f_next  = tsplit.lo;
        end
        else
        begin
            yr          = side_e_reg.year;
            mon_f_next  = 7'(side_e_reg.month);
            day_f_next  = signed'({3'b000, side_e_reg.day});
            hour_f_next = side_e_reg.hour;
            min_f_next  = 7'(side_e_reg.minute);
            sec_f_next  = 7'(side_e_reg.second);
        end

        priority if (yr <= 14'(utcep_pkg::YY_2000_MAX))
        begin
            ty_f_next = yr + 14'(utcep_pkg::CENTURY);
        end
        else if ((yr >= 14'(utcep_pkg::YY_1900_MIN)) && (yr <= 14'(utcep_pkg::YY_1900_MAX)))
        begin
            ty_f_next = yr;
        end
        else if (yr >= 14'(utcep_pkg::CIVIL_BASE))
        begin
            ty_f_next = yr - 14'(utcep_pkg::CIVIL_BASE);
        end
        else
        begin
            ty_f_next = yr;
        end
        yfull_f_next = ty_f_next + 14'(utcep_pkg::CIVIL_BASE);
    end

    // Stage F to G: full year over 25, and the leap-day term truncated towards zero.
    always_comb
    begin
        q25_g_next = 10'((27'(yfull_f_reg) * 27'(utcep_pkg::DIV25_MUL))
                         >> utcep_pkg::DIV25_SHIFT);

        ty_below = ty_f_reg < 14'(utcep_pkg::LEAP_BASE);
        ldiff    = ty_below ? (14'(utcep_pkg::LEAP_BASE) - ty_f_reg)
                            : (ty_f_reg - 14'(utcep_pkg::LEAP_BASE));
        lq_mag   = 12'(ldiff >> 2);
        leapq_g_next = ty_below ? -signed'({1'b0, lq_mag}) : signed'({1'b0, lq_mag});

        hms_g_next = 17'(17'(hour_f_reg) * 17'(utcep_pkg::SEC_PER_HOUR)
                       + 17'(min_f_reg) * 17'(utcep_pkg::SEC_PER_MIN)
                       + 17'(sec_f_reg));
    end

    // Stage G to H: a year divisible by 4 is a leap year unless it is a century year
    // that 400 does not divide; with 25 as the factor, that is a multiple of 16.
    always_comb
    begin
        mult25 = (yfull_g_reg == 14'(q25_g_reg) * 14'(utcep_pkg::CENTURY_25));
        leap   = (yfull_g_reg[1:0] == 2'b00) && (!mult25 || (yfull_g_reg[3:0] == 4'b0000));
        cum    = utcep_pkg::days_before_month(mon_g_reg, leap);

        days_h_next  = signed'({5'b00000, cum}) + 14'(day_g_reg) - 14'sd1 + 14'(leapq_g_reg);
        tyoff_h_next = signed'({1'b0, ty_g_reg}) - 15'(utcep_pkg::EPOCH_YEAR);
    end

    // Stage H to I: scale to seconds; everything wraps at 32 bits.
    always_comb
    begin
        days_ext = 32'(days_h_reg);
        zone_ext = 32'(zone_reg);

        pyear_i_next = 32'(tyoff_h_reg) * 32'(utcep_pkg::SEC_PER_YEAR);
        prest_i_next = days_ext * 32'(utcep_pkg::SEC_PER_DAY) + 32'(hms_h_reg) + zone_ext
                     + 32'(carry_h_reg);
    end

    always_comb
    begin
        result_next.epoch_seconds   = signed'(pyear_i_reg + prest_i_reg);
        result_next.nanoseconds_out = rem_i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            zone_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            zone_reg <= zone_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_a_reg  <= item_a_next;

        side_b_reg  <= side_b_next;
        date_b_reg  <= date_b_next;
        time_b_reg  <= time_b_next;

        side_c_reg  <= side_b_reg;
        side_d_reg  <= side_c_reg;
        side_e_reg  <= side_d_reg;

        ty_f_reg    <= ty_f_next;
        yfull_f_reg <= yfull_f_next;
        mon_f_reg   <= mon_f_next;
        day_f_reg   <= day_f_next;
        hour_f_reg  <= hour_f_next;
        min_f_reg   <= min_f_next;
        sec_f_reg   <= sec_f_next;
        carry_f_reg <= side_e_reg.carry;
        rem_f_reg   <= side_e_reg.rem;

        ty_g_reg    <= ty_f_reg;
        yfull_g_reg <= yfull_f_reg;
        q25_g_reg   <= q25_g_next;
        leapq_g_reg <= leapq_g_next;
        mon_g_reg   <= mon_f_reg;
        day_g_reg   <= day_f_reg;
        hms_g_reg   <= hms_g_next;
        carry_g_reg <= carry_f_reg;
        rem_g_reg   <= rem_f_reg;

        days_h_reg  <= days_h_next;
        tyoff_h_reg <= tyoff_h_next;
        hms_h_reg   <= hms_g_reg;
        carry_h_reg <= carry_g_reg;
        rem_h_reg   <= rem_g_reg;

        pyear_i_reg <= pyear_i_next;
        prest_i_reg <= prest_i_next;
        rem_i_reg   <= rem_h_reg;

        result_reg  <= result_next;
    end

endmodule

// ----- sv/utcep_port_check.sv -----
`timescale 1ns / 1ps

module utcep_port_check (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input utcep_pkg::item_t    item,
    input logic                done,
    input utcep_pkg::result_t  result
);

    logic accept;

    assign accept = start && !busy;

    // Every accepted item is followed by its result strobe on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##10 done)
        else $error("accepted item produced no result after ten cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 10))
        else $error("result strobe without a matching accepted item");

    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.nanoseconds_out < 30'd1000000000))
        else $error("nanoseconds not normalised");

    a_ns_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(item.nanoseconds_in, 10) < 32'd1000000000))
        |-> (result.nanoseconds_out == 30'($past(item.nanoseconds_in, 10))))
        else $error("sub-second nanoseconds changed in transit");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

endmodule

bind utc_civil_to_epoch_seconds utcep_port_check u_port_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .item                (item),
    .done                (done),
    .result              (result)
);

// ----- test/utc_civil_to_epoch_seconds_tb.sv -----
`timescale 1ns / 1ps

module utc_civil_to_epoch_seconds_tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 120;

    class epoch_scoreboard;
        logic signed [17:0]    zone_offset;
        utcep_pkg::result_t    expected_q[$];
        int                    failures;
        int                    month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

        function new();
            zone_offset = '0;
            failures    = 0;
        endfunction

        function void set_offset(logic signed [17:0] value);
            zone_offset = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] seconds_since_epoch(longint year, longint month, longint day,
                                                  longint hour, longint minute,
                                                  longint second);
            longint ty;
            longint yday;
            longint total;
            longint cy;
            bit     leap;
            begin
                ty   = year;
                yday = 0;
                if (ty <= 37)
                begin
                    ty += 2000;
                end
                if (ty >= 70 && ty <= 137)
                begin
                    ty += 1900;
                end
                if (ty >= 1900)
                begin
                    ty -= 1900;
                end
                cy   = ty + 1900;
                leap = (cy % 4 == 0) && ((cy % 400 == 0) || (cy % 100 != 0));
                // The month table saturates: month zero counts nothing, months above
                // December count the whole year.
                for (int i = 0; i < month - 1 && i < 12; i++)
                begin
                    yday += month_len[i];
                    if (i == 1 && leap)
                    begin
                        yday += 1;
                    end
                end
                yday += day - 1;
                // Signed division truncates toward zero, which the leap term relies on.
                total = second + longint'(zone_offset) + minute * 60 + hour * 3600
                      + yday * 86400 + (ty - 70) * 31536000 + ((ty - 69) / 4) * 86400;
                return total[31:0];
            end
        endfunction

        function utcep_pkg::result_t convert(utcep_pkg::item_t it);
            longint             ns;
            longint             d;
            longint             t;
            longint             dd;
            logic [31:0]        secs;
            utcep_pkg::result_t res;
            begin
                ns = longint'(it.nanoseconds_in);
                if (!it.cmd)
                begin
                    secs = seconds_since_epoch(longint'(it.year), longint'(it.month),
                                               longint'(it.day), longint'(it.hour),
                                               longint'(it.minute), longint'(it.second));
                end
                else
                begin
                    d  = longint'(it.date_packed);
                    t  = longint'(it.time_packed);
                    dd = d % 100;
                    // The time word is wrapped by whole days before it is split.
                    while (t < 0)
                    begin
                        t  += 240000;
                        dd -= 1;
                    end
                    while (t > 240000)
                    begin
                        t  -= 240000;
                        dd += 1;
                    end
                    secs = seconds_since_epoch(d / 10000, (d % 10000) / 100, dd,
                                               t / 10000, (t % 10000) / 100, t % 100);
                end
                secs                = secs + 32'(ns / 1000000000);
                res.epoch_seconds   = secs;
                res.nanoseconds_out = 30'(ns % 1000000000);
                return res;
            end
        endfunction

        function void note_item(utcep_pkg::item_t it);
            expected_q.push_back(convert(it));
        endfunction

        function void check_result(utcep_pkg::result_t got);
            utcep_pkg::result_t want;
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d s %0d ns",
                             $time, got.epoch_seconds, got.nanoseconds_out);
                    failures++;
                    return;
                end
                want = expected_q.pop_front();
                if (got.epoch_seconds !== want.epoch_seconds)
                begin
                    $display("%0t: epoch_seconds mismatch: expected %0d, actual %0d",
                             $time, want.epoch_seconds, got.epoch_seconds);
                    failures++;
                end
                if (got.nanoseconds_out !== want.nanoseconds_out)
                begin
                    $display("%0t: nanoseconds_out mismatch: expected %0d, actual %0d",
                             $time, want.nanoseconds_out, got.nanoseconds_out);
                    failures++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    utcep_pkg::item_t   item;
    logic               done;
    utcep_pkg::result_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic signed [17:0] zone_offset_seconds;

    epoch_scoreboard    sb;

    utc_civil_to_epoch_seconds dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .item                (item),
        .done                (done),
        .result              (result),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .zone_offset_seconds (zone_offset_seconds)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // Every transfer on each channel is observed here, at the edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_item(item);
            end
            if (done)
            begin
                sb.check_result(result);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_offset(zone_offset_seconds);
            end
        end
    end

    function automatic utcep_pkg::item_t comp_item(int y, int m, int d, int h, int mi, int s,
                                                   logic [31:0] ns);
        utcep_pkg::item_t it;
        begin
            it                = '0;
            it.cmd            = 1'b0;
            it.year           = 14'(y);
            it.month          = 4'(m);
            it.day            = 5'(d);
            it.hour           = 5'(h);
            it.minute         = 6'(mi);
            it.second         = 6'(s);
            it.nanoseconds_in = ns;
            return it;
        end
    endfunction

    function automatic utcep_pkg::item_t packed_item(int date, int tword, logic [31:0] ns);
        utcep_pkg::item_t it;
        begin
            it                = '0;
            it.cmd            = 1'b1;
            it.date_packed    = 27'(date);
            it.time_packed    = 20'(tword);
            it.nanoseconds_in = ns;
            return it;
        end
    endfunction

    function automatic int pick_year();
        begin
            case ($urandom_range(0, 2))
                0:       return $urandom_range(0, 137);
                1:       return $urandom_range(1900, 2100);
                default: return $urandom_range(0, 9999);
            endcase
        end
    endfunction

    function automatic utcep_pkg::item_t random_item();
        logic [127:0]     raw;
        utcep_pkg::item_t it;
        int               tword;
        begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            it  = utcep_pkg::item_t'(raw[$bits(utcep_pkg::item_t)-1:0]);
            // Most items get in-range date fields; others keep raw random bits.
            if ($urandom_range(0, 99) < 70)
            begin
                it.year   = 14'(pick_year());
                it.month  = 4'($urandom_range(1, 12));
                it.day    = 5'($urandom_range(1, 31));
                it.hour   = 5'($urandom_range(0, 23));
                it.minute = 6'($urandom_range(0, 59));
                it.second = 6'($urandom_range(0, 60));
                it.date_packed = 27'(pick_year() * 10000 + $urandom_range(1, 12) * 100
                                     + $urandom_range(1, 31));
                case ($urandom_range(0, 3))
                    0, 1:    tword = $urandom_range(0, 23) * 10000
                                   + $urandom_range(0, 59) * 100 + $urandom_range(0, 60);
                    2:       tword = $urandom_range(0, 960000) - 480000;
                    default: tword = int'($signed(20'($urandom)));
                endcase
                it.time_packed = 20'(tword);
                if ($urandom_range(0, 1) == 0)
                begin
                    it.nanoseconds_in = $urandom_range(0, 999999999);
                end
            end
            return it;
        end
    endfunction

    task automatic send_item(input utcep_pkg::item_t it);
        begin
            start <= 1'b1;
            item  <= it;
            do
                @(posedge clk);
            while (busy);
        end
    endtask

    task automatic maybe_idle(input bit quiet);
        begin
            if (!quiet && $urandom_range(0, 99) < 12)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (sb.pending() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_offset(input logic signed [17:0] value);
        begin
            repeat ($urandom_range(0, 3)) @(posedge clk);
            cfg_valid           <= 1'b1;
            zone_offset_seconds <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic run_random(input int count, input bit quiet);
        begin
            for (int n = 0; n < count; n++)
            begin
                send_item(random_item());
                maybe_idle(quiet);
            end
        end
    endtask

    initial
    begin
        logic signed [17:0] offsets[6];
        utcep_pkg::item_t   directed[$];

        sb = new();
        rst_n               <= 1'b0;
        start               <= 1'b0;
        item                <= '0;
        cfg_valid           <= 1'b0;
        zone_offset_seconds <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(comp_item(0, 1, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(37, 12, 31, 23, 59, 60, 999999999));
        directed.push_back(comp_item(38, 6, 15, 12, 30, 30, 1000000000));
        directed.push_back(comp_item(69, 1, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(70, 1, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(137, 2, 29, 0, 0, 0, 0));
        directed.push_back(comp_item(138, 3, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(1899, 12, 31, 23, 59, 59, 0));
        directed.push_back(comp_item(2000, 3, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(2100, 3, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(16383, 15, 31, 31, 63, 63, 32'hFFFFFFFF));
        directed.push_back(comp_item(2024, 0, 0, 0, 0, 0, 0));
        directed.push_back(comp_item(2024, 13, 1, 0, 0, 0, 0));
        directed.push_back(comp_item(1970, 1, 1, 0, 0, 0, 32'hFFFFFFFF));
        directed.push_back(packed_item(19700101, 0, 0));
        directed.push_back(packed_item(99991231, 235959, 999999999));
        directed.push_back(packed_item(134217727, 524287, 0));
        directed.push_back(packed_item(20380119, 31407, 0));
        directed.push_back(packed_item(20240229, -1, 0));
        directed.push_back(packed_item(20240301, -480000, 0));
        directed.push_back(packed_item(20240101, -524288, 0));
        directed.push_back(packed_item(20240101, 240000, 0));
        directed.push_back(packed_item(20240101, 240001, 0));
        directed.push_back(packed_item(0, 0, 0));
        directed.push_back(packed_item(371231, 480000, 1000000000));
        foreach (directed[i])
        begin
            send_item(directed[i]);
            maybe_idle(1'b0);
        end

        offsets[0] = 18'sd86400;
        offsets[1] = -18'sd86400;
        offsets[2] = 18'sd131071;
        offsets[3] = -18'sd131072;
        offsets[4] = 18'($urandom);
        offsets[5] = 18'sd0;
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_offset(offsets[p]);
            // One phase runs back-to-back with no gaps between transfers.
            run_random(PHASE_ITEMS, p == 2);
        end

        drain();
        if (sb.failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/utcep_pkg.sv
sv/utcep_dec_split.sv
sv/utc_civil_to_epoch_seconds.sv
sv/utcep_port_check.sv
test/utc_civil_to_epoch_seconds_tb.sv
